// File: hw/rtl/aat_pkg.sv
`default_nettype none

package aat_pkg;

    localparam int REG_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 20;
    localparam int PROD_W     = 32;
    localparam int PART_W     = PROD_W + 1;
    localparam int TOTAL_W    = PROD_W + 2;
    localparam int FRAC_SHIFT = 14;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_XYZ = 3'd3;

    localparam logic [REG_W-1:0] COEF_ROW_X_RESET = 48'h0000_0000_4000;
    localparam logic [REG_W-1:0] COEF_ROW_Y_RESET = 48'h0000_4000_0000;
    localparam logic [REG_W-1:0] COEF_ROW_Z_RESET = 48'h4000_0000_0000;
    localparam logic [REG_W-1:0] OFFSET_XYZ_RESET = 48'h0000_0000_0000;

    localparam logic signed [TOTAL_W-1:0] ROUND_HALF = 34'sd8192;

    typedef struct packed {
        logic signed [IN_W-1:0] box_min_x;
        logic signed [IN_W-1:0] box_min_y;
        logic signed [IN_W-1:0] box_min_z;
        logic signed [IN_W-1:0] box_max_x;
        logic signed [IN_W-1:0] box_max_y;
        logic signed [IN_W-1:0] box_max_z;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_min_x;
        logic signed [OUT_W-1:0] out_min_y;
        logic signed [OUT_W-1:0] out_min_z;
        logic signed [OUT_W-1:0] out_max_x;
        logic signed [OUT_W-1:0] out_max_y;
        logic signed [OUT_W-1:0] out_max_z;
    } out_item_t;

    typedef struct packed {
        logic [REG_W-1:0] coef_row_x;
        logic [REG_W-1:0] coef_row_y;
        logic [REG_W-1:0] coef_row_z;
        logic [REG_W-1:0] offset_xyz;
    } cfg_t;

    // products indexed [output axis][input axis]
    typedef struct packed {
        logic [2:0][2:0][PROD_W-1:0] lo;
        logic [2:0][2:0][PROD_W-1:0] hi;
    } terms_t;

    function automatic logic [IN_W-1:0] lane16(logic [REG_W-1:0] r, logic [1:0] k);
        return r[16*k +: 16];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/aabb_affine_transform_top.sv
// Bounds an axis-aligned box (Q8.8 corners) after the affine transform held in
// the four configuration registers: 3x3 Q2.14 coefficients, row-vector order,
// plus a Q8.8 translation; each bound takes coefficient times min or max by the
// coefficient's sign, and each axis is rounded half up to Q12.8. One box is
// taken every cycle unless the result side stalls, through three register
// stages: operand select and multiply, pair sums, final sum and round into the
// output register. Registers are written through cfg_we, cfg_index, cfg_wdata;
// the user must write them only while no box is in flight, which the block does
// not enforce; other indexes are ignored. Reset loads the identity transform.
`default_nettype none

module aabb_affine_transform_top import aat_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data
);

    cfg_t   cfg;
    logic   t_valid;
    logic   t_ready;
    terms_t t_data;

    aat_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    aat_term_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .t_valid (t_valid),
        .t_ready (t_ready),
        .t_data  (t_data)
    );

    aat_bound_sum u_sum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .t_valid (t_valid),
        .t_ready (t_ready),
        .t_data  (t_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// File: hw/rtl/aat_cfg_regs.sv
`default_nettype none

module aat_cfg_regs import aat_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_wdata,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_COEF_ROW_X: cfg_next.coef_row_x = cfg_wdata;
                REG_COEF_ROW_Y: cfg_next.coef_row_y = cfg_wdata;
                REG_COEF_ROW_Z: cfg_next.coef_row_z = cfg_wdata;
                REG_OFFSET_XYZ: cfg_next.offset_xyz = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_row_x <= COEF_ROW_X_RESET;
            cfg_reg.coef_row_y <= COEF_ROW_Y_RESET;
            cfg_reg.coef_row_z <= COEF_ROW_Z_RESET;
            cfg_reg.offset_xyz <= OFFSET_XYZ_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hw/rtl/aat_term_mul.sv
`default_nettype none

module aat_term_mul import aat_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire cfg_t   cfg,
    input  wire logic   s_valid,
    output logic        s_ready,
    input  wire in_item_t s_data,
    output logic        t_valid,
    input  wire logic   t_ready,
    output terms_t      t_data
);

    logic   valid_reg;
    logic   valid_next;
    terms_t terms_reg;
    terms_t terms_next;

    logic [2:0][IN_W-1:0]  lo_in;
    logic [2:0][IN_W-1:0]  hi_in;
    logic [2:0][REG_W-1:0] rows;

    assign lo_in = {s_data.box_min_z, s_data.box_min_y, s_data.box_min_x};
    assign hi_in = {s_data.box_max_z, s_data.box_max_y, s_data.box_max_x};
    assign rows  = {cfg.coef_row_z, cfg.coef_row_y, cfg.coef_row_x};

    // pick min or max by coefficient sign, then multiply
    always_comb begin
        logic signed [IN_W-1:0] c;
        logic                   pos;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                c   = $signed(lane16(rows[i], 2'(j)));
                pos = (c > 16'sd0);
                terms_next.lo[j][i] = PROD_W'(c) *
                                      PROD_W'($signed(pos ? lo_in[i] : hi_in[i]));
                terms_next.hi[j][i] = PROD_W'(c) *
                                      PROD_W'($signed(pos ? hi_in[i] : lo_in[i]));
            end
        end
    end

    assign s_ready    = !valid_reg || t_ready;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            terms_reg <= terms_next;
        end
    end

    assign t_valid = valid_reg;
    assign t_data  = terms_reg;

endmodule

`default_nettype wire

// File: hw/rtl/aat_bound_sum.sv
`default_nettype none

module aat_bound_sum import aat_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire cfg_t   cfg,
    input  wire logic   t_valid,
    output logic        t_ready,
    input  wire terms_t t_data,
    output logic        m_valid,
    input  wire logic   m_ready,
    output out_item_t   m_data
);

    logic sum_valid_reg;
    logic sum_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic sum_adv;

    logic signed [PART_W-1:0] a_lo_reg [3];
    logic signed [PART_W-1:0] b_lo_reg [3];
    logic signed [PART_W-1:0] a_hi_reg [3];
    logic signed [PART_W-1:0] b_hi_reg [3];
    logic signed [PART_W-1:0] a_lo_next [3];
    logic signed [PART_W-1:0] b_lo_next [3];
    logic signed [PART_W-1:0] a_hi_next [3];
    logic signed [PART_W-1:0] b_hi_next [3];

    logic [2:0][OUT_W-1:0] lo_out_next;
    logic [2:0][OUT_W-1:0] hi_out_next;
    out_item_t             out_reg;

    // pair sums: two products, and the third product with the scaled offset
    always_comb begin
        logic signed [PART_W-1:0] off_ext;
        for (int j = 0; j < 3; j++) begin
            off_ext = $signed({{(PART_W-IN_W-FRAC_SHIFT){cfg.offset_xyz[16*j+15]}},
                               lane16(cfg.offset_xyz, 2'(j)), {FRAC_SHIFT{1'b0}}});
            a_lo_next[j] = $signed({t_data.lo[j][0][PROD_W-1], t_data.lo[j][0]})
                         + $signed({t_data.lo[j][1][PROD_W-1], t_data.lo[j][1]});
            b_lo_next[j] = $signed({t_data.lo[j][2][PROD_W-1], t_data.lo[j][2]}) + off_ext;
            a_hi_next[j] = $signed({t_data.hi[j][0][PROD_W-1], t_data.hi[j][0]})
                         + $signed({t_data.hi[j][1][PROD_W-1], t_data.hi[j][1]});
            b_hi_next[j] = $signed({t_data.hi[j][2][PROD_W-1], t_data.hi[j][2]}) + off_ext;
        end
    end

    // final sum, round half up, floor-shift
    always_comb begin
        logic signed [TOTAL_W-1:0] tot_lo;
        logic signed [TOTAL_W-1:0] tot_hi;
        for (int j = 0; j < 3; j++) begin
            tot_lo = TOTAL_W'(a_lo_reg[j]) + TOTAL_W'(b_lo_reg[j]) + ROUND_HALF;
            tot_hi = TOTAL_W'(a_hi_reg[j]) + TOTAL_W'(b_hi_reg[j]) + ROUND_HALF;
            lo_out_next[j] = tot_lo[FRAC_SHIFT +: OUT_W];
            hi_out_next[j] = tot_hi[FRAC_SHIFT +: OUT_W];
        end
    end

    assign sum_adv        = !out_valid_reg || m_ready;
    assign t_ready        = !sum_valid_reg || sum_adv;
    assign sum_valid_next = t_ready ? t_valid : sum_valid_reg;
    assign out_valid_next = sum_adv ? sum_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_valid_reg <= sum_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (t_valid && t_ready) begin
            for (int j = 0; j < 3; j++) begin
                a_lo_reg[j] <= a_lo_next[j];
                b_lo_reg[j] <= b_lo_next[j];
                a_hi_reg[j] <= a_hi_next[j];
                b_hi_reg[j] <= b_hi_next[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_valid_reg && sum_adv) begin
            out_reg.out_min_x <= lo_out_next[0];
            out_reg.out_min_y <= lo_out_next[1];
            out_reg.out_min_z <= lo_out_next[2];
            out_reg.out_max_x <= hi_out_next[0];
            out_reg.out_max_y <= hi_out_next[1];
            out_reg.out_max_z <= hi_out_next[2];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/aat_checker.sv
`default_nettype none

module aat_checker import aat_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction dropped or changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_no_early_result: assert property (@(posedge aclk)
        !aresetn ##1 aresetn ##1 aresetn |=> !m_valid)
        else $error("result appeared before pipeline could fill");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

endmodule

bind aabb_affine_transform_top aat_checker u_aat_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// File: bench/aabb_affine_transform_top_tb.sv
`timescale 1ns / 100ps

module aabb_affine_transform_top_tb;
    import aat_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_BOXES = 228;
    localparam int DRAIN_TAIL  = 4;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] = '{
        REG_COEF_ROW_X, REG_COEF_ROW_Y, REG_COEF_ROW_Z, REG_OFFSET_XYZ
    };

    typedef struct {
        int        cfg_sel;
        in_item_t  box;
        bit        typed;
        out_item_t bounds;
    } box_case_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_data;

    cfg_t      xform_cfg;
    cfg_t      cfg_sets [6];
    box_case_t box_cases [$];
    out_item_t pending_bounds [$];
    int        bound_errors;
    int        cycle_count;
    bit        tx_idle;
    bit        rx_idle;
    int        rx_holdoff;

    aabb_affine_transform_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic out_item_t bound_box(in_item_t b, cfg_t c);
        logic [REG_W-1:0] rows [3];
        longint           lo [3];
        longint           hi [3];
        longint           smin;
        longint           smax;
        longint           coef;
        logic [OUT_W-1:0] omin [3];
        logic [OUT_W-1:0] omax [3];
        out_item_t        r;
        rows = '{c.coef_row_x, c.coef_row_y, c.coef_row_z};
        lo = '{longint'($signed(b.box_min_x)), longint'($signed(b.box_min_y)),
               longint'($signed(b.box_min_z))};
        hi = '{longint'($signed(b.box_max_x)), longint'($signed(b.box_max_y)),
               longint'($signed(b.box_max_z))};
        for (int j = 0; j < 3; j++) begin
            smin = longint'($signed(c.offset_xyz[16*j +: 16])) * 16384;
            smax = smin;
            for (int i = 0; i < 3; i++) begin
                coef = longint'($signed(rows[i][16*j +: 16]));
                if (coef > 0) begin
                    smin += coef * lo[i];
                    smax += coef * hi[i];
                end else begin
                    smin += coef * hi[i];
                    smax += coef * lo[i];
                end
            end
            smin = (smin + 8192) >>> FRAC_SHIFT;
            smax = (smax + 8192) >>> FRAC_SHIFT;
            omin[j] = smin[OUT_W-1:0];
            omax[j] = smax[OUT_W-1:0];
        end
        r.out_min_x = omin[0];
        r.out_min_y = omin[1];
        r.out_min_z = omin[2];
        r.out_max_x = omax[0];
        r.out_max_y = omax[1];
        r.out_max_z = omax[2];
        return r;
    endfunction

    function automatic in_item_t box_of(int nx, int ny, int nz, int xx, int xy, int xz);
        in_item_t b;
        b.box_min_x = IN_W'(nx);
        b.box_min_y = IN_W'(ny);
        b.box_min_z = IN_W'(nz);
        b.box_max_x = IN_W'(xx);
        b.box_max_y = IN_W'(xy);
        b.box_max_z = IN_W'(xz);
        return b;
    endfunction

    function automatic out_item_t bounds_of(int nx, int ny, int nz, int xx, int xy, int xz);
        out_item_t r;
        r.out_min_x = OUT_W'(nx);
        r.out_min_y = OUT_W'(ny);
        r.out_min_z = OUT_W'(nz);
        r.out_max_x = OUT_W'(xx);
        r.out_max_y = OUT_W'(xy);
        r.out_max_z = OUT_W'(xz);
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] rand_lane();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'h4000;
            4: return 16'hC000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic cfg_t rand_cfg();
        cfg_t c;
        c.coef_row_x = {rand_lane(), rand_lane(), rand_lane()};
        c.coef_row_y = {rand_lane(), rand_lane(), rand_lane()};
        c.coef_row_z = {rand_lane(), rand_lane(), rand_lane()};
        c.offset_xyz = {rand_lane(), rand_lane(), rand_lane()};
        return c;
    endfunction

    function automatic logic [IN_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_item_t rand_box();
        logic signed [IN_W-1:0] a [6];
        logic signed [IN_W-1:0] t;
        for (int k = 0; k < 6; k++) a[k] = rand_coord();
        // keep most boxes well ordered, leave the rest inverted or mixed
        if ($urandom_range(0, 4) != 0) begin
            for (int k = 0; k < 3; k++) begin
                if (a[k] > a[k+3]) begin
                    t = a[k];
                    a[k] = a[k+3];
                    a[k+3] = t;
                end
            end
        end
        return box_of(a[0], a[1], a[2], a[3], a[4], a[5]);
    endfunction

    task automatic add_case(int sel, in_item_t b, bit typed, out_item_t r);
        box_case_t bc;
        bc.cfg_sel = sel;
        bc.box = b;
        bc.typed = typed;
        bc.bounds = r;
        box_cases.push_back(bc);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_bounds.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    task automatic apply_cfg(cfg_t c);
        logic [REG_W-1:0] vals [4];
        drain();
        vals = '{c.coef_row_x, c.coef_row_y, c.coef_row_z, c.offset_xyz};
        // last write goes to an unused index and must change nothing
        for (int k = 0; k < 5; k++) begin
            cfg_we <= 1'b1;
            if (k < 4) begin
                cfg_index <= REG_ORDER[k];
                cfg_wdata <= vals[k];
            end else begin
                cfg_index <= CFG_IDX_W'(REG_OFFSET_XYZ + 1 + $urandom_range(0, 3));
                cfg_wdata <= REG_W'({$urandom, $urandom});
            end
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        xform_cfg = c;
    endtask

    task automatic send_box(in_item_t b, out_item_t want);
        int gap;
        gap = tx_idle ? idle_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
        pending_bounds.push_back(want);
    endtask

    task automatic check_bounds(out_item_t got);
        out_item_t        want;
        logic [OUT_W-1:0] g [6];
        logic [OUT_W-1:0] w [6];
        bit               bad;
        if (pending_bounds.size() == 0) begin
            bound_errors++;
            if (bound_errors <= 10)
                $display("unexpected transaction on result side: %p", got);
            return;
        end
        want = pending_bounds.pop_front();
        g = '{got.out_min_x, got.out_min_y, got.out_min_z,
              got.out_max_x, got.out_max_y, got.out_max_z};
        w = '{want.out_min_x, want.out_min_y, want.out_min_z,
              want.out_max_x, want.out_max_y, want.out_max_z};
        bad = 1'b0;
        for (int k = 0; k < 6; k++)
            if (g[k] !== w[k]) bad = 1'b1;
        if (bad) begin
            bound_errors++;
            if (bound_errors <= 10)
                $display("bounds mismatch: expected %p, actual %p", want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_bounds(m_data);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int n;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (rx_holdoff > 0) begin
                n = rx_holdoff;
                rx_holdoff = 0;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                n = rx_idle ? idle_len() : 0;
                if (n == 0) begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        int        cur_sel;
        cfg_t      c;
        in_item_t  b;
        out_item_t want;

        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        bound_errors = 0;
        cycle_count = 0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        rx_holdoff = 0;
        xform_cfg = cfg_t'{COEF_ROW_X_RESET, COEF_ROW_Y_RESET, COEF_ROW_Z_RESET,
                           OFFSET_XYZ_RESET};

        cfg_sets[0] = xform_cfg;
        cfg_sets[1] = cfg_t'{48'h0000_0000_C000, 48'h0000_C000_0000, 48'hC000_0000_0000,
                             48'h0100_0100_0100};
        cfg_sets[2] = cfg_t'{{3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}};
        cfg_sets[3] = cfg_t'{{3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}};
        cfg_sets[4] = cfg_t'{48'h0, 48'h0, 48'h0, 48'h7FFF_FEDC_1234};
        cfg_sets[5] = cfg_t'{48'hE000_E000_2000, 48'hE000_2000_E000, 48'h2000_E000_E000,
                             48'hFF80_0080_0001};

        // identity after reset: bounds are the corners widened
        add_case(0, box_of(0, 0, 0, 0, 0, 0), 1, bounds_of(0, 0, 0, 0, 0, 0));
        add_case(0, box_of(-32768, -32768, -32768, 32767, 32767, 32767), 1,
                 bounds_of(-32768, -32768, -32768, 32767, 32767, 32767));
        add_case(0, box_of(32767, 32767, 32767, -32768, -32768, -32768), 1,
                 bounds_of(32767, 32767, 32767, -32768, -32768, -32768));
        add_case(0, box_of(1, -1, 256, -1, 1, -256), 1,
                 bounds_of(1, -1, 256, -1, 1, -256));
        add_case(0, box_of(21845, -21846, 21845, -21846, 21845, -21846), 1,
                 bounds_of(21845, -21846, 21845, -21846, 21845, -21846));
        add_case(1, box_of(0, 0, 0, 0, 0, 0), 0, '0);
        add_case(1, box_of(-32768, -256, 5, 32767, 256, 700), 0, '0);
        add_case(2, box_of(-32768, -32768, -32768, 32767, 32767, 32767), 0, '0);
        add_case(2, box_of(32767, 32767, 32767, -32768, -32768, -32768), 0, '0);
        add_case(3, box_of(-32768, -32768, -32768, 32767, 32767, 32767), 0, '0);
        add_case(3, box_of(32767, -32768, 32767, -32768, 32767, -32768), 0, '0);
        // zero coefficients: only the translation survives
        add_case(4, box_of(-32768, 100, 32767, 32767, -100, -32768), 1,
                 bounds_of(4660, -292, 32767, 4660, -292, 32767));
        add_case(4, box_of(0, 0, 0, 0, 0, 0), 1,
                 bounds_of(4660, -292, 32767, 4660, -292, 32767));
        add_case(5, box_of(1, -1, 1, 1, -1, 1), 0, '0);
        add_case(5, box_of(-1, 1, -1, 2, 3, -2), 0, '0);
        add_case(5, box_of(-32768, -32768, -32768, 32767, 32767, 32767), 0, '0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        cur_sel = 0;
        foreach (box_cases[k]) begin
            if (box_cases[k].cfg_sel != cur_sel) begin
                cur_sel = box_cases[k].cfg_sel;
                apply_cfg(cfg_sets[cur_sel]);
            end
            want = box_cases[k].typed ? box_cases[k].bounds
                                      : bound_box(box_cases[k].box, xform_cfg);
            send_box(box_cases[k].box, want);
        end

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: c = cfg_sets[2];
                1: c = cfg_sets[3];
                7: c = cfg_sets[0];
                default: c = rand_cfg();
            endcase
            apply_cfg(c);
            tx_idle = (ph != 2);
            rx_idle = (ph != 2);
            for (int n = 0; n < PHASE_BOXES; n++) begin
                // hold the result side off while boxes keep coming, then let it drain
                if (ph == 4 && n == 100) begin
                    rx_holdoff = 300;
                    tx_idle = 1'b0;
                end
                if (ph == 4 && n == 170) begin
                    tx_idle = 1'b1;
                    drain();
                end
                b = rand_box();
                send_box(b, bound_box(b, xform_cfg));
            end
        end

        drain();
        if (bound_errors == 0 && pending_bounds.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: aabb_affine_transform_top.f
hw/rtl/aat_pkg.sv
hw/rtl/aat_cfg_regs.sv
hw/rtl/aat_term_mul.sv
hw/rtl/aat_bound_sum.sv
hw/rtl/aabb_affine_transform_top.sv
hw/rtl/aat_checker.sv
bench/aabb_affine_transform_top_tb.sv
